// ----- design/mte_pkg.sv -----
// shared types, register codes and constants for the multi-tap echo
package mte_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_HISTORY_DEPTH = 1048576;
    localparam int DEF_MAX_TAPS      = 9;
    localparam int DEF_SAMPLE_BITS   = 24;

    // fixed register field widths
    localparam int DELAY_W    = 16;
    localparam int TAPS_W     = 4;
    localparam int GAIN_W     = 16;
    localparam int RATIO_W    = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;

    // register reset values
    localparam logic [DELAY_W-1:0] RST_DELAY = 16'd44100;
    localparam logic [TAPS_W-1:0]  RST_TAPS  = 4'd4;
    localparam logic [GAIN_W-1:0]  RST_GAIN  = 16'd32768;
    localparam logic [RATIO_W-1:0] RST_RATIO = 17'd65536;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DELAY = 2'd0,
        CFG_TAPS  = 2'd1,
        CFG_GAIN  = 2'd2,
        CFG_RATIO = 2'd3
    } t_cfg_reg;

    // live configuration seen by the engine
    typedef struct packed {
        logic [DELAY_W-1:0] delay_samples;
        logic [TAPS_W-1:0]  tap_count;
        logic [GAIN_W-1:0]  first_gain;
        logic [RATIO_W-1:0] tap_ratio;
    } t_cfg;

    // engine status toward the top level
    typedef struct packed {
        logic busy;
        logic res_valid;
    } t_eng_stat;

    // engine sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TAP   = 5'b00010,
        S_WRITE = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_eng_state;

endpackage

// ----- design/mte_hist_ram.sv -----
// stereo sample history memory, one write port and one registered read port
module mte_hist_ram import mte_pkg::*; #(
    parameter int DEPTH = DEF_HISTORY_DEPTH,
    parameter int AW    = 20,
    parameter int DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/mte_engine.sv -----
// tap sequencer, gain chain and multiply-accumulate around the history memory
module mte_engine import mte_pkg::*; #(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int MAX_TAPS      = DEF_MAX_TAPS,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_in_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_right_sample,
    output t_eng_stat                     o_stat,
    input  logic                          i_res_take,
    output logic signed [SAMPLE_BITS-1:0] o_left_res,
    output logic signed [SAMPLE_BITS-1:0] o_right_res
);

    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int DW     = 2 * SAMPLE_BITS;
    localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
    localparam int ACC_W  = SAMPLE_BITS + GAIN_W + $clog2(MAX_TAPS + 1) + 1;
    localparam int GP_W   = GAIN_W + RATIO_W;
    localparam logic [AW:0]         DEPTH_C   = (AW + 1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0]       LAST_ADDR = AW'(HISTORY_DEPTH - 1);
    localparam logic [TAPS_W-1:0]   MAX_TAPS_C = TAPS_W'(MAX_TAPS);
    localparam logic [GP_W-1:0]     G_HALF    = GP_W'(1) << (GAIN_W - 1);
    localparam logic signed [ACC_W-1:0] Q_MAX = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Q_MIN = -Q_MAX - ACC_W'(1);

    t_eng_state                   r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_x_l, r_x_r;
    logic [TAPS_W-1:0]            r_left;
    logic [AW-1:0]                r_k;
    logic [GAIN_W-1:0]            r_gain;
    logic [AW-1:0]                r_wp;
    logic                         r_full;
    logic                         r_s1_valid;
    logic                         r_s1_live;
    logic [GAIN_W-1:0]            r_s1_gain;
    logic                         r_p_valid;
    logic signed [PROD_W-1:0]     r_prod_l, r_prod_r;
    logic signed [ACC_W-1:0]      r_acc_l, r_acc_r;

    logic                         w_in_acc;
    logic [TAPS_W-1:0]            w_taps;
    logic                         w_no_taps;
    logic [AW:0]                  w_k_sum;
    logic [AW-1:0]                w_k_next;
    logic [AW:0]                  w_diff;
    logic [AW-1:0]                w_idx;
    logic                         w_live;
    logic [GP_W-1:0]              w_grnd;
    logic [GAIN_W-1:0]            w_g_next;
    logic [DW-1:0]                w_rd_data;
    logic signed [SAMPLE_BITS-1:0] w_hist_l, w_hist_r;
    logic signed [ACC_W-1:0]      w_q_l, w_q_r;

    // request acceptance and tap count clamp
    assign w_in_acc  = i_in_valid && (r_state == S_IDLE);
    assign w_taps    = (i_cfg.tap_count > MAX_TAPS_C) ? MAX_TAPS_C : i_cfg.tap_count;
    assign w_no_taps = (i_cfg.delay_samples == '0) || (w_taps == '0);

    // next tap distance, modulo the history depth
    assign w_k_sum  = {1'b0, r_k} + (AW + 1)'(i_cfg.delay_samples);
    assign w_k_next = (w_k_sum >= DEPTH_C) ? AW'(w_k_sum - DEPTH_C) : w_k_sum[AW-1:0];

    // read address behind the write pointer, wrapped
    assign w_diff = {1'b0, r_wp} - {1'b0, r_k};
    assign w_idx  = w_diff[AW] ? AW'(w_diff + DEPTH_C) : w_diff[AW-1:0];

    // entries are written in address order from reset, so the pointer marks the fill
    assign w_live = r_full || (w_idx < r_wp);

    // gain chain step: round to Q0.16 and saturate
    assign w_grnd   = GP_W'(r_gain) * GP_W'(i_cfg.tap_ratio) + G_HALF;
    assign w_g_next = (|w_grnd[GP_W-1:2*GAIN_W]) ? {GAIN_W{1'b1}}
                                                 : w_grnd[2*GAIN_W-1:GAIN_W];

    mte_hist_ram #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_WRITE),
        .i_wr_addr (r_wp),
        .i_wr_data ({r_x_l, r_x_r}),
        .i_rd_addr (w_idx),
        .o_rd_data (w_rd_data)
    );

    // never written entries read as zero
    assign w_hist_l = r_s1_live ? $signed(w_rd_data[DW-1:SAMPLE_BITS]) : '0;
    assign w_hist_r = r_s1_live ? $signed(w_rd_data[SAMPLE_BITS-1:0]) : '0;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_no_taps ? S_WRITE : S_TAP;
                end
            end
            S_TAP: begin
                if (r_left == TAPS_W'(1)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: n_state = S_DRAIN;
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wp       <= '0;
            r_full     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_p_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= (r_state == S_TAP);
            r_p_valid  <= r_s1_valid;
            if (r_state == S_WRITE) begin
                if (r_wp == LAST_ADDR) begin
                    r_wp   <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wp <= r_wp + AW'(1);
                end
            end
        end
    end

    // tap walk: distance, gain and remaining count
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x_l  <= i_left_sample;
            r_x_r  <= i_right_sample;
            r_left <= w_taps;
            r_k    <= AW'(i_cfg.delay_samples);
            r_gain <= i_cfg.first_gain;
        end else if (r_state == S_TAP) begin
            r_left <= r_left - TAPS_W'(1);
            r_k    <= w_k_next;
            r_gain <= w_g_next;
        end
    end

    // read stage: gain and fill flag travel with the read
    always_ff @(posedge i_clk) begin
        r_s1_live <= w_live;
        r_s1_gain <= r_gain;
    end

    // product stage
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_prod_l <= w_hist_l * $signed({1'b0, r_s1_gain});
            r_prod_r <= w_hist_r * $signed({1'b0, r_s1_gain});
        end
    end

    // accumulate: dry sample scaled to Q.39, then each tap product
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_acc_l <= ACC_W'(i_left_sample) <<< GAIN_W;
            r_acc_r <= ACC_W'(i_right_sample) <<< GAIN_W;
        end else if (r_p_valid) begin
            r_acc_l <= r_acc_l + ACC_W'(r_prod_l);
            r_acc_r <= r_acc_r + ACC_W'(r_prod_r);
        end
    end

    // round once (floor of sum plus half) and saturate
    assign w_q_l = (r_acc_l + $signed(ACC_W'(G_HALF))) >>> GAIN_W;
    assign w_q_r = (r_acc_r + $signed(ACC_W'(G_HALF))) >>> GAIN_W;

    assign o_left_res  = (w_q_l > Q_MAX) ? SAMPLE_BITS'(Q_MAX)
                       : (w_q_l < Q_MIN) ? SAMPLE_BITS'(Q_MIN) : SAMPLE_BITS'(w_q_l);
    assign o_right_res = (w_q_r > Q_MAX) ? SAMPLE_BITS'(Q_MAX)
                       : (w_q_r < Q_MIN) ? SAMPLE_BITS'(Q_MIN) : SAMPLE_BITS'(w_q_r);

    assign o_stat.busy      = (r_state != S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);

endmodule

// ----- design/multi_tap_echo.sv -----
// top level of the stereo multi-tap echo: config registers, engine and output register
//
// Input channel: i_in_valid with o_in_stall carries one stereo request
// (i_left_sample, i_right_sample, signed Q1.23). Output channel: o_out_valid
// with i_out_stall carries one stereo result (o_left_out, o_right_out) per request.
// Each output is the dry sample plus tap_count echoes spaced delay_samples apart,
// the first scaled by first_gain and each later one by tap_ratio more, saturated.
// The engine works on one request at a time and reads its echo taps one by one
// (at most MAX_TAPS, none when delay or tap count is zero): the history memory has
// one read port and each echo tap needs one read. A new request is taken while a
// finished result still sits in the output register; the engine holds its next
// result until that register frees up. Configuration must be written through
// i_cfg_we / i_cfg_addr / i_cfg_wdata only while idle; the block does not enforce it.
// Reset restores the register defaults and empties the history: the write pointer
// tracks which entries were written since reset, unwritten entries read as zero,
// so no clearing pass is needed and requests are taken right after reset.
module multi_tap_echo import mte_pkg::*; #(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int MAX_TAPS      = DEF_MAX_TAPS,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]         i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_right_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out
);

    t_cfg                          r_cfg;
    t_eng_stat                     w_stat;
    logic                          w_res_take;
    logic                          w_in_acc;
    logic signed [SAMPLE_BITS-1:0] w_res_left, w_res_right;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_left_out, r_right_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_samples <= RST_DELAY;
            r_cfg.tap_count     <= RST_TAPS;
            r_cfg.first_gain    <= RST_GAIN;
            r_cfg.tap_ratio     <= RST_RATIO;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DELAY: r_cfg.delay_samples <= i_cfg_wdata[DELAY_W-1:0];
                CFG_TAPS:  r_cfg.tap_count     <= i_cfg_wdata[TAPS_W-1:0];
                CFG_GAIN:  r_cfg.first_gain    <= i_cfg_wdata[GAIN_W-1:0];
                CFG_RATIO: r_cfg.tap_ratio     <= i_cfg_wdata[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    mte_engine #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_TAPS      (MAX_TAPS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_stat         (w_stat),
        .i_res_take     (w_res_take),
        .o_left_res     (w_res_left),
        .o_right_res    (w_res_right)
    );

    assign o_in_stall = w_stat.busy;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // result moves to the output register when it is empty or being drained
    assign w_res_take = w_stat.res_valid && (!r_out_valid || !i_out_stall);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_left_out  <= w_res_left;
            r_right_out <= w_res_right;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

    // a taken request keeps the engine busy in the next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> w_stat.busy)
        else $error("engine idle right after taking a request");

    // handing a result over frees the engine and fills the output register
    a_take_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_take |=> o_out_valid && !w_stat.busy)
        else $error("result handoff did not free the engine");

    // a finished result waits unchanged until the output register takes it
    a_res_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.res_valid && !w_res_take |=>
            w_stat.res_valid && $stable(w_res_left) && $stable(w_res_right))
        else $error("pending result lost or changed");

    // a delivered result with nothing behind it empties the output register
    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !w_res_take |=> !o_out_valid)
        else $error("result delivered twice");

endmodule
